// ----- sv/stim_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the sorted table.
package stim_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int CMD_W       = 2;
  localparam int STATUS_W    = 3;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT        = 2'd0,
    CMD_INSERT_UNIQUE = 2'd1,
    CMD_READ_ALL      = 2'd2,
    CMD_CLEAR         = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_ENTRY     = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_CLEARED   = 3'd5
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic    capture;
    logic    insert;
    logic    rotate;
    logic    clear;
    logic    out_load;
    status_e out_status;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
    logic empty;
    logic full;
    logic dup_hit;
    logic last_entry;
  } dp_stat_t;

endpackage

// ----- sv/stim_datapath.sv -----
// Datapath: row of compare-and-shift cells, fill count, read index and output register.
module stim_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic signed [stim_pkg::VALUE_WIDTH-1:0] in_value,
  input  stim_pkg::dp_cmd_t                    cmd,
  output stim_pkg::dp_stat_t                   stat,
  input  logic                                 m_tready,
  output logic                                 m_tvalid,
  // status[2:0], entry_value[34:3], position[40:35], fill_count[47:41]
  output logic [stim_pkg::OUT_TDATA_W-1:0]     m_tdata,
  output logic                                 m_tlast
);

  localparam int D  = stim_pkg::TABLE_DEPTH;
  localparam int VW = stim_pkg::VALUE_WIDTH;
  localparam int IW = stim_pkg::IDX_W;
  localparam int CW = stim_pkg::CNT_W;
  localparam int SW = stim_pkg::STATUS_W;

  logic signed [VW-1:0] tbl      [D];
  logic signed [VW-1:0] tbl_next [D];
  logic [CW-1:0]        cnt;
  logic [IW-1:0]        idx;
  logic signed [VW-1:0] x;
  logic [D-1:0]         le;
  logic [D-1:0]         eq;
  logic [D-1:0]         le_in;
  logic [D-1:0]         eq_in;
  logic [IW-1:0]        ins_pos;
  logic [IW-1:0]        dup_pos;

  logic                 out_valid;
  logic [SW-1:0]        o_status;
  logic [VW-1:0]        o_value;
  logic [IW-1:0]        o_pos;
  logic [CW-1:0]        o_fill;
  logic                 o_last;
  logic [VW-1:0]        n_value;
  logic [IW-1:0]        n_pos;
  logic [CW-1:0]        n_fill;
  logic                 n_last;

  // per-cell compares against the incoming value
  always_comb begin
    for (int i = 0; i < D; i++) begin
      le_in[i] = (CW'(i) < cnt) && (tbl[i] <= in_value);
      eq_in[i] = (CW'(i) < cnt) && (tbl[i] == in_value);
    end
  end

  // le is a thermometer, eq a contiguous run: each has one boundary cell
  always_comb begin
    ins_pos = '0;
    dup_pos = '0;
    for (int i = 0; i < D; i++) begin
      if (!le[i] && (i == 0 || le[(i + D - 1) % D])) ins_pos = ins_pos | IW'(i);
      if (eq[i] && (i == 0 || !eq[(i + D - 1) % D])) dup_pos = dup_pos | IW'(i);
    end
  end

  always_comb begin
    for (int i = 0; i < D; i++) begin
      tbl_next[i] = tbl[i];
      if (cmd.insert) begin
        if (!le[i]) begin
          if (i == 0 || le[(i + D - 1) % D]) tbl_next[i] = x;
          else tbl_next[i] = tbl[(i + D - 1) % D];
        end
      end else begin
        // rotate the filled part by one so entry 0 always holds the next entry
        if (CW'(i) == cnt - 1'b1) tbl_next[i] = tbl[0];
        else if (CW'(i) < cnt - 1'b1) tbl_next[i] = tbl[(i + 1) % D];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert || cmd.rotate) begin
      for (int i = 0; i < D; i++) tbl[i] <= tbl_next[i];
    end
    if (cmd.capture) begin
      x  <= in_value;
      le <= le_in;
      eq <= eq_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      idx <= '0;
    end else begin
      if (cmd.clear) cnt <= '0;
      else if (cmd.insert) cnt <= cnt + 1'b1;
      if (cmd.capture) idx <= '0;
      else if (cmd.rotate) idx <= idx + 1'b1;
    end
  end

  assign stat.out_free   = !out_valid || m_tready;
  assign stat.empty      = (cnt == '0);
  assign stat.full       = (cnt == CW'(D));
  assign stat.dup_hit    = |eq;
  assign stat.last_entry = ((CW'(idx) + 1'b1) == cnt);

  always_comb begin
    n_value = '0;
    n_pos   = '0;
    n_fill  = cnt;
    n_last  = 1'b1;
    case (cmd.out_status)
      stim_pkg::ST_INSERTED: begin
        n_pos  = ins_pos;
        n_fill = cnt + 1'b1;
      end
      stim_pkg::ST_DUPLICATE: n_pos = dup_pos;
      stim_pkg::ST_ENTRY: begin
        n_value = tbl[0];
        n_pos   = idx;
        n_last  = stat.last_entry;
      end
      stim_pkg::ST_CLEARED: n_fill = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_status <= cmd.out_status;
      o_value  <= n_value;
      o_pos    <= n_pos;
      o_fill   <= n_fill;
      o_last   <= n_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {o_fill, o_pos, o_value, o_status};
  assign m_tlast  = o_last;

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= CW'(D))
    else $error("fill count beyond table depth");
  a_ins_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |-> !stat.full)
    else $error("insert into full table");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> stat.out_free)
    else $error("output register overwritten");
  a_ins_count: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |=> cnt == $past(cnt) + 1'b1)
    else $error("fill count did not advance on insert");

endmodule

// ----- sv/stim_ctrl.sv -----
// Controller state machine sequencing insert, read-out and clear.
module stim_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [stim_pkg::CMD_W-1:0]    in_cmd,
  input  stim_pkg::dp_stat_t            stat,
  output stim_pkg::dp_cmd_t             cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_INS   = 5'b00010,
    S_INSU  = 5'b00100,
    S_READ  = 5'b01000,
    S_CLR   = 5'b10000
  } state_t;

  state_t state, state_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    cmd.capture    = 1'b0;
    cmd.insert     = 1'b0;
    cmd.rotate     = 1'b0;
    cmd.clear      = 1'b0;
    cmd.out_load   = 1'b0;
    cmd.out_status = stim_pkg::ST_INSERTED;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          case (in_cmd)
            stim_pkg::CMD_INSERT:        state_next = S_INS;
            stim_pkg::CMD_INSERT_UNIQUE: state_next = S_INSU;
            stim_pkg::CMD_READ_ALL:      state_next = S_READ;
            default:                     state_next = S_CLR;
          endcase
        end
      end
      S_INS, S_INSU: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
          // search precedes the fullness test
          if (state == S_INSU && stat.dup_hit) begin
            cmd.out_status = stim_pkg::ST_DUPLICATE;
          end else if (stat.full) begin
            cmd.out_status = stim_pkg::ST_FULL;
          end else begin
            cmd.out_status = stim_pkg::ST_INSERTED;
            cmd.insert     = 1'b1;
          end
        end
      end
      S_READ: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          if (stat.empty) begin
            cmd.out_status = stim_pkg::ST_EMPTY;
            state_next     = S_IDLE;
          end else begin
            cmd.out_status = stim_pkg::ST_ENTRY;
            cmd.rotate     = 1'b1;
            if (stat.last_entry) state_next = S_IDLE;
          end
        end
      end
      S_CLR: begin
        if (stat.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = stim_pkg::ST_CLEARED;
          cmd.clear      = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> (state == S_IDLE))
    else $error("capture outside idle");
  a_single_action: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.insert, cmd.rotate, cmd.clear}))
    else $error("conflicting table actions");

endmodule

// ----- sv/sorted_table_insert_merge_top.sv -----
// Top level of the sorted table with insert, unique merge, read-out and clear.
// Insert and insert-if-absent: accept and compare in the idle state, then shift through
// the cell row and register the result in the insert state.
// Read-out: after accept, one entry per cycle by rotating the cell row while the output is free.
// Clear: accept, then clear. Output stalls hold the controller in its current state.
// Synchronous reset empties the table and the output register; entry contents are kept.
module sorted_table_insert_merge_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // command[1:0], value[33:2], zero pad[39:34]
  input  logic [stim_pkg::IN_TDATA_W-1:0]   s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // status[2:0], entry_value[34:3], position[40:35], fill_count[47:41]
  output logic [stim_pkg::OUT_TDATA_W-1:0]  m_tdata,
  output logic                              m_tlast
);

  stim_pkg::dp_cmd_t  cmd;
  stim_pkg::dp_stat_t stat;
  logic signed [stim_pkg::VALUE_WIDTH-1:0] in_value;

  assign in_value = s_tdata[stim_pkg::CMD_W +: stim_pkg::VALUE_WIDTH];

  stim_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .in_cmd   (s_tdata[stim_pkg::CMD_W-1:0]),
    .stat     (stat),
    .cmd      (cmd)
  );

  stim_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_value (in_value),
    .cmd      (cmd),
    .stat     (stat),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
